@@ rtl/conv2x2_same_pad_accumulator_defines.svh @@
// Assertion macros for the 2x2 convolution accumulator.
`ifndef CONV2X2_SAME_PAD_ACCUMULATOR_DEFINES_SVH
`define CONV2X2_SAME_PAD_ACCUMULATOR_DEFINES_SVH

// Condition holds at every rising clock edge out of reset.
`define C2SP_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define C2SP_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/c2sp_pkg.sv @@
// Shared types and constants of the 2x2 convolution accumulator.
`timescale 1ns / 1ps

package c2sp_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_IN_CH  = 256;
    localparam int DEF_ACC_BITS   = 48;

    localparam int RST_IMAGE_WIDTH  = 64;
    localparam int RST_IMAGE_HEIGHT = 64;
    localparam int RST_IN_CHANNELS  = 1;

    localparam int TAP_W      = 2;
    localparam int CHAN_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int RESULT_W   = 48;
    localparam int NUM_TAPS   = 4;
    localparam int DIM_REG_W  = 7;
    localparam int CH_REG_W   = 9;
    localparam int REG_IDX_W  = 2;
    localparam int REG_DATA_W = 9;

    // Result queue entries, one per pixel that finishes outputs.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic
    {
        CMD_WEIGHT = 1'b0,
        CMD_PIXEL  = 1'b1
    } command_t;

    typedef enum logic [REG_IDX_W-1:0]
    {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_IN_CHANNELS  = 2'd2
    } reg_index_t;

    // Outputs finished by one pixel; slot k is in raster order, slot 3 is (row, col).
    typedef struct packed {
        logic [NUM_TAPS-1:0]                mask;
        logic [ROW_W-1:0]                   row;
        logic [COL_W-1:0]                   col;
        logic [NUM_TAPS-1:0][RESULT_W-1:0]  value;
    } result_rec_t;

endpackage

@@ rtl/c2sp_item_if.sv @@
// Input channel: weight loads and pixels.
`timescale 1ns / 1ps

interface c2sp_item_if;
    import c2sp_pkg::*;

    logic                        valid;
    logic                        ready;
    command_t                    command;
    logic [TAP_W-1:0]            weight_tap;
    logic [CHAN_W-1:0]           weight_channel;
    logic signed [SAMPLE_W-1:0]  sample_value;

    modport source (output valid, output command, output weight_tap,
                    output weight_channel, output sample_value, input ready);
    modport sink   (input valid, input command, input weight_tap,
                    input weight_channel, input sample_value, output ready);
endinterface

@@ rtl/c2sp_result_if.sv @@
// Output channel: finished output pixels.
`timescale 1ns / 1ps

interface c2sp_result_if;
    import c2sp_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [ROW_W-1:0]            out_row;
    logic [COL_W-1:0]            out_col;
    logic signed [RESULT_W-1:0]  result_value;
    logic                        frame_last;

    modport source (output valid, output out_row, output out_col,
                    output result_value, output frame_last, input ready);
    modport sink   (input valid, input out_row, input out_col,
                    input result_value, input frame_last, output ready);
endinterface

@@ rtl/c2sp_cfg_if.sv @@
// Configuration write channel.
`timescale 1ns / 1ps

interface c2sp_cfg_if;
    import c2sp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [REG_IDX_W-1:0]   reg_index;
    logic [REG_DATA_W-1:0]  wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ rtl/conv2x2_same_pad_accumulator.sv @@
// One output channel of a 2x2 stride-1 same-padded convolution, Q8.8 in, exact Q32.16 out.
// Sustained rate is one request per cycle, weight or pixel, while the input is not stalled. The accumulator
// plane is split into four banks, each with one read and one write port, by row and column parity. The four
// targets of a pixel land in different banks, so one read plus one write per bank each cycle keeps up. A
// pixel's results pass through stage 1, stage 2, the result queue and the output register to the result port.
// On the last channel a pixel finishes 0 to 4 outputs (4 at the bottom-right corner); they drain one per
// cycle from a 4-entry queue while the result port is ready, and the input stalls only while the queue plus
// the two pipeline stages hold 4 pixels that finish outputs. Weights and accumulators need no clearing pass:
// an accumulator is seeded by the first channel.
`timescale 1ns / 1ps
`include "conv2x2_same_pad_accumulator_defines.svh"

module conv2x2_same_pad_accumulator #(
    parameter int MAX_WIDTH  = c2sp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c2sp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_IN_CH  = c2sp_pkg::DEF_MAX_IN_CH,
    parameter int ACC_BITS   = c2sp_pkg::DEF_ACC_BITS
)(
    input  logic           clk,
    input  logic           rst_n,
    c2sp_item_if.sink      item,
    c2sp_result_if.source  result,
    c2sp_cfg_if.sink       cfg
);
    import c2sp_pkg::*;

    localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CHW = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
    localparam int XH  = (XW > 1) ? XW - 1 : 1;
    localparam int YH  = (YW > 1) ? YW - 1 : 1;
    localparam int AW  = XH + YH;
    localparam int BANK_DEPTH = 1 << AW;
    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    function automatic int unsigned clamp_last(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 0;
        if (v > hi)
            return hi - 1;
        return v - 1;
    endfunction

    localparam logic [XW-1:0]  WMAX_RST = XW'(clamp_last(RST_IMAGE_WIDTH, MAX_WIDTH));
    localparam logic [YW-1:0]  HMAX_RST = YW'(clamp_last(RST_IMAGE_HEIGHT, MAX_HEIGHT));
    localparam logic [CHW-1:0] CMAX_RST = CHW'(clamp_last(RST_IN_CHANNELS, MAX_IN_CH));

    // ---------------- configuration and position counters ----------------
    logic [XW-1:0]  wmax_reg, wmax_next;
    logic [YW-1:0]  hmax_reg, hmax_next;
    logic [CHW-1:0] cmax_reg, cmax_next;
    logic [XW-1:0]  col_count_reg, col_count_next;
    logic [YW-1:0]  row_count_reg, row_count_next;
    logic [CHW-1:0] chan_count_reg, chan_count_next;
    logic           cfg_fire, cfg_hit;
    logic           item_fire, pixel_fire, weight_fire, ch_ok;
    logic           credit_ok;
    logic [QCW:0]   credit_sum;
    logic [NUM_TAPS-1:0] accept_mask;

    assign cfg.ready   = 1'b1;
    assign cfg_fire    = cfg.valid && cfg.ready;
    assign item.ready  = credit_ok;
    assign item_fire   = item.valid && item.ready;
    assign pixel_fire  = item_fire && (item.command == CMD_PIXEL);
    assign weight_fire = item_fire && (item.command == CMD_WEIGHT);
    assign ch_ok       = 32'(item.weight_channel) < MAX_IN_CH;

    always_comb
    begin
        wmax_next       = wmax_reg;
        hmax_next       = hmax_reg;
        cmax_next       = cmax_reg;
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        chan_count_next = chan_count_reg;
        cfg_hit         = 1'b0;
        if (cfg_fire)
        begin
            unique case (reg_index_t'(cfg.reg_index))
                REG_IMAGE_WIDTH:
                begin
                    wmax_next = XW'(clamp_last(32'(cfg.wr_data[DIM_REG_W-1:0]), MAX_WIDTH));
                    cfg_hit   = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    hmax_next = YW'(clamp_last(32'(cfg.wr_data[DIM_REG_W-1:0]), MAX_HEIGHT));
                    cfg_hit   = 1'b1;
                end
                REG_IN_CHANNELS:
                begin
                    cmax_next = CHW'(clamp_last(32'(cfg.wr_data[CH_REG_W-1:0]), MAX_IN_CH));
                    cfg_hit   = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        if (cfg_hit)
        begin
            col_count_next  = '0;
            row_count_next  = '0;
            chan_count_next = '0;
        end
        else if (pixel_fire)
        begin
            if (col_count_reg == wmax_reg)
            begin
                col_count_next = '0;
                if (row_count_reg == hmax_reg)
                begin
                    row_count_next  = '0;
                    chan_count_next = (chan_count_reg == cmax_reg) ? '0
                                                                   : chan_count_reg + 1'b1;
                end
                else
                begin
                    row_count_next = row_count_reg + 1'b1;
                end
            end
            else
            begin
                col_count_next = col_count_reg + 1'b1;
            end
        end
    end

    // Outputs this pixel finishes, raster order: (y-1,x-1) (y-1,x) (y,x-1) (y,x)
    always_comb
    begin
        accept_mask[0] = (chan_count_reg == cmax_reg) && (row_count_reg != '0)
                         && (col_count_reg != '0);
        accept_mask[1] = (chan_count_reg == cmax_reg) && (row_count_reg != '0)
                         && (col_count_reg == wmax_reg);
        accept_mask[2] = (chan_count_reg == cmax_reg) && (row_count_reg == hmax_reg)
                         && (col_count_reg != '0);
        accept_mask[3] = (chan_count_reg == cmax_reg) && (row_count_reg == hmax_reg)
                         && (col_count_reg == wmax_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wmax_reg       <= WMAX_RST;
            hmax_reg       <= HMAX_RST;
            cmax_reg       <= CMAX_RST;
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            chan_count_reg <= '0;
        end
        else
        begin
            wmax_reg       <= wmax_next;
            hmax_reg       <= hmax_next;
            cmax_reg       <= cmax_next;
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
            chan_count_reg <= chan_count_next;
        end
    end

    // ---------------- weight banks, one per tap ----------------
    logic signed [SAMPLE_W-1:0] wq_reg [NUM_TAPS];

    for (genvar t = 0; t < NUM_TAPS; t++)
    begin : gen_wbank
        logic [SAMPLE_W-1:0] wmem [MAX_IN_CH];

        always_ff @(posedge clk)
        begin
            if (weight_fire && ch_ok && (item.weight_tap == TAP_W'(t)))
                wmem[CHW'(item.weight_channel)] <= item.sample_value;
            if (pixel_fire)
                wq_reg[t] <= $signed(wmem[chan_count_reg]);
        end
    end

    // ---------------- stage 1: multiply, issue accumulator reads ----------------
    logic                       s1_valid_reg;
    logic [NUM_TAPS-1:0]        s1_mask_reg;
    logic [XW-1:0]              s1_x_reg;
    logic [YW-1:0]              s1_y_reg;
    logic                       s1_first_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic signed [PROD_W-1:0]   s1_prod [NUM_TAPS];
    logic [AW-1:0]              s1_addr [NUM_TAPS];
    logic [NUM_TAPS-1:0]        s1_en;

    always_comb
    begin
        for (int t = 0; t < NUM_TAPS; t++)
            s1_prod[t] = wq_reg[t] * s1_sample_reg;
    end

    // Bank b holds target tap b ^ {y[0], x[0]}: stepping back a row or column flips parity.
    always_comb
    begin
        logic [1:0]    tap;
        logic [YW-1:0] row;
        logic [XW-1:0] col;
        for (int b = 0; b < NUM_TAPS; b++)
        begin
            tap        = 2'(b) ^ {s1_y_reg[0], s1_x_reg[0]};
            row        = s1_y_reg - YW'(tap[1]);
            col        = s1_x_reg - XW'(tap[0]);
            s1_addr[b] = {YH'(row >> 1), XH'(col >> 1)};
        end
        s1_en[0] = 1'b1;
        s1_en[1] = (s1_x_reg != '0);
        s1_en[2] = (s1_y_reg != '0);
        s1_en[3] = (s1_x_reg != '0) && (s1_y_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (pixel_fire)
        begin
            s1_mask_reg   <= accept_mask;
            s1_x_reg      <= col_count_reg;
            s1_y_reg      <= row_count_reg;
            s1_first_reg  <= (chan_count_reg == '0);
            s1_sample_reg <= item.sample_value;
        end
    end

    // ---------------- accumulator banks, read-modify-write ----------------
    logic                     s2_valid_reg;
    logic [NUM_TAPS-1:0]      s2_mask_reg;
    logic [NUM_TAPS-1:0]      s2_en_reg;
    logic [1:0]               s2_par_reg;
    logic                     s2_first_reg;
    logic [ROW_W-1:0]         s2_row_reg;
    logic [COL_W-1:0]         s2_col_reg;
    logic signed [PROD_W-1:0] s2_prod_reg [NUM_TAPS];
    logic [AW-1:0]            s2_addr_reg [NUM_TAPS];
    logic [ACC_BITS-1:0]      acc_q [NUM_TAPS];
    logic [ACC_BITS-1:0]      acc_new [NUM_TAPS];
    logic [NUM_TAPS-1:0]      bank_we;
    logic [NUM_TAPS-1:0]      fwd_valid_reg;
    logic [AW-1:0]            fwd_addr_reg [NUM_TAPS];
    logic [ACC_BITS-1:0]      fwd_data_reg [NUM_TAPS];

    for (genvar b = 0; b < NUM_TAPS; b++)
    begin : gen_abank
        logic [ACC_BITS-1:0] amem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
                amem[s2_addr_reg[b]] <= acc_new[b];
            if (s1_valid_reg)
                acc_q[b] <= amem[s1_addr[b]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_mask_reg  <= s1_mask_reg;
            s2_en_reg    <= s1_en;
            s2_par_reg   <= {s1_y_reg[0], s1_x_reg[0]};
            s2_first_reg <= s1_first_reg;
            s2_row_reg   <= ROW_W'(s1_y_reg);
            s2_col_reg   <= COL_W'(s1_x_reg);
            for (int t = 0; t < NUM_TAPS; t++)
            begin
                s2_prod_reg[t] <= s1_prod[t];
                s2_addr_reg[t] <= s1_addr[t];
            end
        end
    end

    // A read issued in the same cycle as the previous write to its bank returns stale
    // data; the last write of each bank is kept and forwarded on an address match.
    always_comb
    begin
        logic [1:0]          tap;
        logic [ACC_BITS-1:0] base;
        logic [ACC_BITS-1:0] addend;
        for (int b = 0; b < NUM_TAPS; b++)
        begin
            tap    = 2'(b) ^ s2_par_reg;
            base   = (fwd_valid_reg[b] && (fwd_addr_reg[b] == s2_addr_reg[b]))
                     ? fwd_data_reg[b] : acc_q[b];
            addend = ACC_BITS'(s2_prod_reg[tap]);
            // first channel seeds the accumulator from the r0s0 product
            acc_new[b] = ((tap == 2'd0) && s2_first_reg) ? addend : base + addend;
            bank_we[b] = s2_valid_reg && s2_en_reg[tap];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < NUM_TAPS; b++)
        begin
            if (bank_we[b])
            begin
                fwd_addr_reg[b] <= s2_addr_reg[b];
                fwd_data_reg[b] <= acc_new[b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= pixel_fire;
            s2_valid_reg  <= s1_valid_reg;
            fwd_valid_reg <= fwd_valid_reg | bank_we;
        end
    end

    // ---------------- result queue ----------------
    result_rec_t      push_rec;
    logic             q_push, q_pop;
    result_rec_t      q_mem [QUEUE_DEPTH];
    logic [QPW-1:0]   q_wr_ptr_reg, q_rd_ptr_reg;
    logic [QCW-1:0]   q_count_reg;

    always_comb
    begin
        logic [1:0] bank;
        push_rec.mask = s2_mask_reg;
        push_rec.row  = s2_row_reg;
        push_rec.col  = s2_col_reg;
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            // slot k is the target of tap 3 - k
            bank              = (2'd3 - 2'(k)) ^ s2_par_reg;
            push_rec.value[k] = RESULT_W'($signed(acc_new[bank]));
        end
    end

    assign q_push = s2_valid_reg && (s2_mask_reg != '0);

    assign credit_sum = (QCW + 1)'(q_count_reg)
                        + (QCW + 1)'(s1_valid_reg && (s1_mask_reg != '0))
                        + (QCW + 1)'(s2_valid_reg && (s2_mask_reg != '0));
    assign credit_ok  = credit_sum < (QCW + 1)'(QUEUE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
        end
        else
        begin
            if (q_push)
                q_wr_ptr_reg <= (q_wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : q_wr_ptr_reg + 1'b1;
            if (q_pop)
                q_rd_ptr_reg <= (q_rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : q_rd_ptr_reg + 1'b1;
            q_count_reg <= q_count_reg + QCW'(q_push) - QCW'(q_pop);
        end
    end

    // The drain moves one output per cycle into the output register while the result port is ready.
    result_rec_t          head;
    logic [NUM_TAPS-1:0]  done_reg, done_next;
    logic [NUM_TAPS-1:0]  pend, slot_bit;
    logic [1:0]           slot;
    logic                 out_free, out_load;
    logic                 out_valid_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic [RESULT_W-1:0]  out_value_reg;
    logic                 out_last_reg;

    assign head     = q_mem[q_rd_ptr_reg];
    assign pend     = head.mask & ~done_reg;
    assign out_free = !out_valid_reg || result.ready;
    assign out_load = (q_count_reg != '0) && out_free;

    always_comb
    begin
        priority if (pend[0])
            slot = 2'd0;
        else if (pend[1])
            slot = 2'd1;
        else if (pend[2])
            slot = 2'd2;
        else
            slot = 2'd3;
        slot_bit = NUM_TAPS'(1) << slot;
        q_pop    = out_load && ((pend & ~slot_bit) == '0);
        if (q_pop)
            done_next = '0;
        else if (out_load)
            done_next = done_reg | slot_bit;
        else
            done_next = done_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg   <= slot[1] ? head.row : head.row - 1'b1;
            out_col_reg   <= slot[0] ? head.col : head.col - 1'b1;
            out_value_reg <= head.value[slot];
            out_last_reg  <= (slot == 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_row      = out_row_reg;
    assign result.out_col      = out_col_reg;
    assign result.result_value = $signed(out_value_reg);
    assign result.frame_last   = out_last_reg;

    // ---------------- assertions ----------------
    `C2SP_ASSERT_ALWAYS(a_credit_bound, credit_sum <= (QCW + 1)'(QUEUE_DEPTH),
        "result queue reservations exceed its depth")
    `C2SP_ASSERT_ALWAYS(a_count_range,
        (col_count_reg <= wmax_reg) && (row_count_reg <= hmax_reg)
            && (chan_count_reg <= cmax_reg),
        "position counters outside the configured plane")
    `C2SP_ASSERT_IMPLY(a_last_corner, result.valid && result.frame_last,
        (result.out_col == COL_W'(wmax_reg)) && (result.out_row == ROW_W'(hmax_reg)),
        "frame_last on an output other than the bottom-right corner")

endmodule

@@ sim/conv2x2_same_pad_accumulator_test.sv @@
// Self-checking testbench for the 2x2 same-padded convolution accumulator.
`timescale 1ns / 1ps

module conv2x2_same_pad_accumulator_test;
    import c2sp_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int RANDOM_ITEMS  = 82;

    // Index past the register list: accepted, changes nothing.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic signed [RESULT_W-1:0] value;
        logic                       last;
    } pixel_out_t;

    typedef enum bit
    {
        STEP_CONFIG  = 1'b0,
        STEP_REQUEST = 1'b1
    } step_kind_t;

    typedef struct packed {
        step_kind_t          kind;
        command_t            cmd;
        logic [1:0]          sel;
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] value;
        bit                  typed;
        pixel_out_t          want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    c2sp_item_if   item ();
    c2sp_result_if result ();
    c2sp_cfg_if    cfg ();

    conv2x2_same_pad_accumulator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state
    logic [SAMPLE_W-1:0] coef_mem [0:DEF_MAX_IN_CH*NUM_TAPS-1];
    bit   [DEF_MAX_IN_CH*NUM_TAPS-1:0] coef_loaded = '0;
    logic [RESULT_W-1:0] acc_mem [0:DEF_MAX_HEIGHT*DEF_MAX_WIDTH-1];
    int unsigned scan_col = 0;
    int unsigned scan_row = 0;
    int unsigned scan_chan = 0;
    logic [DIM_REG_W-1:0] width_reg  = DIM_REG_W'(RST_IMAGE_WIDTH);
    logic [DIM_REG_W-1:0] height_reg = DIM_REG_W'(RST_IMAGE_HEIGHT);
    logic [CH_REG_W-1:0]  chans_reg  = CH_REG_W'(RST_IN_CHANNELS);

    pixel_out_t pending_outputs [$];
    int fail_count = 0;
    bit calm = 1'b0;

    function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [RESULT_W-1:0] tap_product(logic [SAMPLE_W-1:0] w,
                                                        logic [SAMPLE_W-1:0] p);
        logic signed [PROD_W-1:0] prod;
        prod = $signed(w) * $signed(p);
        return {{(RESULT_W-PROD_W){prod[PROD_W-1]}}, prod};
    endfunction

    function automatic pixel_out_t finished_output(int unsigned r, int unsigned c, bit last);
        pixel_out_t o;
        o.row   = ROW_W'(r);
        o.col   = COL_W'(c);
        o.value = acc_mem[r*DEF_MAX_WIDTH + c];
        o.last  = last;
        return o;
    endfunction

    // Adds one pixel into the plane; queues the outputs it finishes when record is set.
    function automatic void predict_pixel(logic [SAMPLE_W-1:0] sample, bit record);
        int unsigned w, h, nc, x, y, c, base;
        pixel_out_t done [$];
        bit right, bottom;
        w  = eff_dim(width_reg, DEF_MAX_WIDTH);
        h  = eff_dim(height_reg, DEF_MAX_HEIGHT);
        nc = eff_dim(chans_reg, DEF_MAX_IN_CH);
        x = scan_col;
        y = scan_row;
        c = scan_chan;
        if (x >= w || y >= h || c >= nc)
        begin
            x = 0;
            y = 0;
            c = 0;
        end
        base = c * NUM_TAPS;

        // channel 0 seeds the entry rather than adding to it
        if (c == 0)
            acc_mem[y*DEF_MAX_WIDTH + x] = tap_product(coef_mem[base], sample);
        else
            acc_mem[y*DEF_MAX_WIDTH + x] += tap_product(coef_mem[base], sample);
        if (x >= 1)
            acc_mem[y*DEF_MAX_WIDTH + x - 1] += tap_product(coef_mem[base + 1], sample);
        if (y >= 1)
            acc_mem[(y-1)*DEF_MAX_WIDTH + x] += tap_product(coef_mem[base + 2], sample);
        if (x >= 1 && y >= 1)
            acc_mem[(y-1)*DEF_MAX_WIDTH + x - 1] += tap_product(coef_mem[base + 3], sample);

        if (c == nc - 1)
        begin
            right  = (x == w - 1);
            bottom = (y == h - 1);
            if (y >= 1 && x >= 1)
                done.push_back(finished_output(y - 1, x - 1, 1'b0));
            if (y >= 1 && right)
                done.push_back(finished_output(y - 1, x, 1'b0));
            if (bottom && x >= 1)
                done.push_back(finished_output(y, x - 1, 1'b0));
            if (bottom && right)
                done.push_back(finished_output(y, x, 1'b1));
        end
        if (record)
            foreach (done[i])
                pending_outputs.push_back(done[i]);

        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            if (y >= h)
            begin
                y = 0;
                c++;
                if (c >= nc)
                    c = 0;
            end
        end
        scan_col  = x;
        scan_row  = y;
        scan_chan = c;
    endfunction

    function automatic plan_row_t cfg_row(logic [1:0] sel, logic [REG_DATA_W-1:0] data);
        plan_row_t r;
        r = '0;
        r.kind  = STEP_CONFIG;
        r.sel   = sel;
        r.value = SAMPLE_W'(data);
        return r;
    endfunction

    function automatic plan_row_t coef_row(logic [1:0] tap, logic [CHAN_W-1:0] ch,
                                           logic [SAMPLE_W-1:0] v);
        plan_row_t r;
        r = '0;
        r.kind  = STEP_REQUEST;
        r.cmd   = CMD_WEIGHT;
        r.sel   = tap;
        r.chan  = ch;
        r.value = v;
        return r;
    endfunction

    function automatic plan_row_t pix_row(logic [SAMPLE_W-1:0] v);
        plan_row_t r;
        r = '0;
        r.kind  = STEP_REQUEST;
        r.cmd   = CMD_PIXEL;
        r.value = v;
        return r;
    endfunction

    function automatic plan_row_t pix_want(logic [SAMPLE_W-1:0] v, int unsigned row,
                                           int unsigned col, logic signed [RESULT_W-1:0] sum,
                                           bit last);
        plan_row_t r;
        r = pix_row(v);
        r.typed      = 1'b1;
        r.want.row   = ROW_W'(row);
        r.want.col   = COL_W'(col);
        r.want.value = sum;
        r.want.last  = last;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Width/height code; bits above the register width are ignored by the block.
    function automatic logic [REG_DATA_W-1:0] dim_code(int unsigned d);
        logic [1:0] junk;
        junk = 2'($urandom_range(0, 3));
        if (d == 1 && $urandom_range(0, 1) == 1)
            return {junk, 7'd0};
        if (d == DEF_MAX_WIDTH && $urandom_range(0, 1) == 1)
            return {junk, 7'($urandom_range(DEF_MAX_WIDTH + 1, 127))};
        return {junk, 7'(d)};
    endfunction

    function automatic logic [REG_DATA_W-1:0] chan_code(int unsigned n);
        if (n == 1 && $urandom_range(0, 1) == 1)
            return '0;
        return REG_DATA_W'(n);
    endfunction

    task automatic wait_drained();
        item.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] sel,
                                  input logic [REG_DATA_W-1:0] data);
        wait_drained();
        cfg.valid     <= 1'b1;
        cfg.reg_index <= sel;
        cfg.wr_data   <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (sel)
            REG_IMAGE_WIDTH:  width_reg  = data[DIM_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = data[DIM_REG_W-1:0];
            REG_IN_CHANNELS:  chans_reg  = data[CH_REG_W-1:0];
            default:          return;
        endcase
        scan_col  = 0;
        scan_row  = 0;
        scan_chan = 0;
    endtask

    // Sends one request; valid stays high afterwards unless the next call idles first.
    task automatic issue(input plan_row_t r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid          <= 1'b1;
        item.command        <= r.cmd;
        item.weight_tap     <= r.sel;
        item.weight_channel <= r.chan;
        item.sample_value   <= r.value;
        do
            @(posedge clk);
        while (!item.ready);
        if (r.cmd == CMD_WEIGHT)
        begin
            coef_mem[r.chan*NUM_TAPS + r.sel] = r.value;
            coef_loaded[r.chan*NUM_TAPS + r.sel] = 1'b1;
        end
        else
        begin
            predict_pixel(r.value, !r.typed);
            if (r.typed)
                pending_outputs.push_back(r.want);
        end
    endtask

    // Result side: random back-pressure and in-order compare.
    initial
    begin
        int hold;
        pixel_out_t want, got;
        result.ready = 1'b0;
        hold = $urandom_range(0, 6);
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                got.row   = result.out_row;
                got.col   = result.out_col;
                got.value = result.result_value;
                got.last  = result.frame_last;
                if (pending_outputs.size() == 0)
                begin
                    $display("%0t: unexpected output (%0d,%0d) %0d last %0b", $time,
                             got.row, got.col, $signed(got.value), got.last);
                    fail_count++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected (%0d,%0d) %0d last %0b, got (%0d,%0d) %0d last %0b",
                                 $time, want.row, want.col, $signed(want.value), want.last,
                                 got.row, got.col, $signed(got.value), got.last);
                        fail_count++;
                    end
                end
                hold = calm ? 0 : $urandom_range(0, 6);
                if (hold != 0)
                    result.ready <= 1'b0;
            end
            else if (!result.ready)
            begin
                if (hold <= 1)
                    result.ready <= 1'b1;
                else
                    hold--;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        plan_row_t plan [$];
        int w_dim, h_dim, nc_dim, frame_px, px_total, first;
        int rand_items;
        bit paused_once;

        item.valid          = 1'b0;
        item.command        = CMD_WEIGHT;
        item.weight_tap     = '0;
        item.weight_channel = '0;
        item.sample_value   = '0;
        cfg.valid           = 1'b0;
        cfg.reg_index       = '0;
        cfg.wr_data         = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset geometry, 1x1 extremes, two channels, then a 2x2 frame whose
        // last pixel finishes all four outputs.
        plan.push_back(coef_row(2'd0, 8'd0, 16'h0100));
        plan.push_back(pix_row(16'h1234));
        plan.push_back(cfg_row(REG_IMAGE_WIDTH, 9'h180));
        plan.push_back(cfg_row(REG_IMAGE_HEIGHT, 9'h000));
        plan.push_back(coef_row(2'd0, 8'd0, 16'h8000));
        plan.push_back(pix_want(16'h8000, 0, 0, 48'sh0000_4000_0000, 1'b1));
        plan.push_back(coef_row(2'd0, 8'd0, 16'h7FFF));
        plan.push_back(pix_want(16'h8000, 0, 0, -48'sd1073709056, 1'b1));
        plan.push_back(pix_want(16'h7FFF, 0, 0, 48'sd1073676289, 1'b1));
        plan.push_back(pix_want(16'h0000, 0, 0, 48'sd0, 1'b1));
        plan.push_back(cfg_row(REG_IN_CHANNELS, 9'd2));
        plan.push_back(coef_row(2'd0, 8'd1, 16'hFFFF));
        plan.push_back(pix_row(16'h0100));
        plan.push_back(pix_row(16'h0100));
        plan.push_back(cfg_row(REG_IMAGE_WIDTH, 9'd2));
        plan.push_back(cfg_row(REG_IMAGE_HEIGHT, 9'd2));
        plan.push_back(cfg_row(REG_IN_CHANNELS, 9'd1));
        plan.push_back(coef_row(2'd1, 8'd0, 16'h8000));
        plan.push_back(coef_row(2'd2, 8'd0, 16'h0080));
        plan.push_back(coef_row(2'd3, 8'd0, 16'hC000));
        plan.push_back(pix_row(16'h7FFF));
        plan.push_back(pix_row(16'h8000));
        plan.push_back(cfg_row(REG_UNUSED, 9'h1FF));
        plan.push_back(pix_row(16'hFFFF));
        plan.push_back(pix_row(16'h8000));

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_CONFIG)
                write_register(plan[i].sel, plan[i].value[REG_DATA_W-1:0]);
            else
                issue(plan[i]);
        end

        // Channel count past the maximum clamps to 256: six pixels of a 1x1 frame
        // over that many channels finish nothing.
        write_register(REG_IMAGE_WIDTH, 9'd1);
        write_register(REG_IMAGE_HEIGHT, 9'h080);
        write_register(REG_IN_CHANNELS, 9'h1FF);
        for (int ch = 2; ch < 6; ch++)
            issue(coef_row(2'd0, CHAN_W'(ch), pick_sample()));
        for (int n = 0; n < 6; n++)
            issue(pix_row(pick_sample()));

        // Random phases: well-formed frames with random content, some cut short,
        // with stray weight loads mixed in.
        rand_items = 0;
        paused_once = 1'b0;
        while (rand_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:
                begin
                    w_dim = DEF_MAX_WIDTH;
                    h_dim = $urandom_range(1, 2);
                    nc_dim = 1;
                end
                1:
                begin
                    w_dim = $urandom_range(1, 2);
                    h_dim = DEF_MAX_HEIGHT;
                    nc_dim = 1;
                end
                default:
                begin
                    w_dim = $urandom_range(1, 5);
                    h_dim = $urandom_range(1, 5);
                    nc_dim = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6)
                                                         : $urandom_range(1, 3);
                end
            endcase

            first = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
                case ((first + i) % 3)
                    0: write_register(REG_IMAGE_WIDTH, dim_code(w_dim));
                    1: write_register(REG_IMAGE_HEIGHT, dim_code(h_dim));
                    default: write_register(REG_IN_CHANNELS, chan_code(nc_dim));
                endcase
            calm = ($urandom_range(0, 3) == 0);

            for (int ch = 0; ch < nc_dim; ch++)
                if (!(&coef_loaded[ch*NUM_TAPS +: NUM_TAPS]) || $urandom_range(0, 1) == 1)
                    for (int tap = 0; tap < NUM_TAPS; tap++)
                    begin
                        issue(coef_row(2'(tap), CHAN_W'(ch), pick_sample()));
                        rand_items++;
                    end

            frame_px = nc_dim * w_dim * h_dim;
            px_total = frame_px * $urandom_range(1, 2);
            if (frame_px > 1 && $urandom_range(0, 2) == 0)
                px_total -= $urandom_range(1, frame_px - 1);
            // keep the run near its item budget
            if (px_total > RANDOM_ITEMS - rand_items)
                px_total = RANDOM_ITEMS - rand_items;
            if (px_total < 1)
                px_total = 1;

            for (int n = 0; n < px_total; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    issue(coef_row(2'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 255)),
                                   pick_sample()));
                    rand_items++;
                end
                // hold the sender mid-frame until the output side runs dry
                if (n == px_total / 2 && (!paused_once || $urandom_range(0, 5) == 0))
                begin
                    paused_once = 1'b1;
                    if ($urandom_range(0, 1) == 1)
                        write_register(REG_UNUSED, REG_DATA_W'($urandom));
                    else
                        wait_drained();
                end
                issue(pix_row(pick_sample()));
                rand_items++;
            end
        end

        calm = 1'b0;
        wait_drained();
        if (fail_count == 0 && pending_outputs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
